// ===== rtl/mme_pkg.sv =====
// Shared types and codes for the matrix multiply engine.
package mme_pkg;

  localparam int DIM_W   = 7;   // width of a dimension register
  localparam int IDX_W   = 6;   // width of a row or column index field
  localparam int ELEM_W  = 16;  // signed Q8.8 element
  localparam int PROD_W  = 32;  // signed Q16.16 product
  localparam int SUM_W   = 38;  // signed Q22.16 accumulator
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_N      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_K     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_B = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_a;       // store the input beat into A
    logic             wr_b;       // store the input beat into B
    logic             b_swap;     // B beat carries (column, depth)
    logic             latch_row;  // capture the row of a compute
    logic             issue;      // read A(row,k) and B(k,j) into the MAC pipe
    logic             acc_clear;  // first term of a new dot product
    logic             out_load;   // move the finished sum to the output
    logic             out_last;
    logic [DIM_W-1:0] k;
    logic [IDX_W-1:0] j;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drained;   // no product in flight, accumulator settled
    logic out_free;  // output register can take a new result
  } status_t;

endpackage

// ===== rtl/matrix_multiply_engine_top.sv =====
// Top level of the matrix multiply engine: controller plus datapath.
//
// Load beats (operation 0 or 1) write one Q8.8 element of A or B. A compute
// beat (operation 2) stalls the input until its row is done and emits one beat
// per column of C with the exact Q22.16 dot product, last set on the final
// column. A single multiply-accumulate unit does one product per cycle behind a
// registered store read and a registered multiply; after each column it waits
// for the pipe to drain and, while the output is stalled, for the result
// register to be free. The result register lets the input take new beats while
// the last result of a row still waits. The element stores hold no reset value;
// every element must be loaded before a compute reads it.
module matrix_multiply_engine_top
  import mme_pkg::*;
#(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int MAX_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic [IDX_W-1:0]         row_index,
  input  logic [IDX_W-1:0]         col_index,
  input  logic signed [ELEM_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [SUM_W-1:0]  dot_sum,
  output logic                     last
);

  cmd_t    cmd;
  status_t status;

  mme_ctrl #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .row_index (row_index),
    .status    (status),
    .cmd       (cmd)
  );

  mme_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .row_index (row_index),
    .col_index (col_index),
    .value     (value),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .dot_sum   (dot_sum),
    .last      (last)
  );

endmodule

// ===== rtl/mme_datapath.sv =====
// Datapath: element stores, multiply-accumulate pipeline and output register.
module mme_datapath
  import mme_pkg::*;
#(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int MAX_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic [IDX_W-1:0]         row_index,
  input  logic [IDX_W-1:0]         col_index,
  input  logic signed [ELEM_W-1:0] value,
  output status_t                  status,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [SUM_W-1:0]  dot_sum,
  output logic                     last
);

  localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
  localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

  logic [ELEM_W-1:0] a_mem [A_DEPTH];
  logic [ELEM_W-1:0] b_mem [B_DEPTH];

  logic [IDX_W-1:0]         row;
  logic [A_AW-1:0]          a_waddr;
  logic [A_AW-1:0]          a_raddr;
  logic [B_AW-1:0]          b_waddr;
  logic [B_AW-1:0]          b_raddr;
  logic [IDX_W-1:0]         bk;
  logic [IDX_W-1:0]         bj;
  logic                     a_ok;
  logic                     b_ok;
  logic [ELEM_W-1:0]        a_rd;
  logic [ELEM_W-1:0]        b_rd;
  logic                     rd_valid;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic signed [SUM_W-1:0]  acc;

  // A transposed B beat swaps the roles of its row and column fields.
  assign bk = cmd.b_swap ? col_index : row_index;
  assign bj = cmd.b_swap ? row_index : col_index;

  assign a_ok = (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_DEPTH);
  assign b_ok = (32'(bk) < MAX_DEPTH) && (32'(bj) < MAX_COLS);

  assign a_waddr = A_AW'(32'(row_index) * MAX_DEPTH + 32'(col_index));
  assign b_waddr = B_AW'(32'(bk) * MAX_COLS + 32'(bj));
  assign a_raddr = A_AW'(32'(row) * MAX_DEPTH + 32'(cmd.k));
  assign b_raddr = B_AW'(32'(cmd.k) * MAX_COLS + 32'(cmd.j));

  always_ff @(posedge clk) begin
    if (cmd.wr_a && a_ok) begin
      a_mem[a_waddr] <= value;
    end
    a_rd <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b && b_ok) begin
      b_mem[b_waddr] <= value;
    end
    b_rd <= b_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_row) begin
      row <= row_index;
    end
  end

  // Two-stage MAC: registered read, registered product, then accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= cmd.issue;
      prod_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(a_rd) * $signed(b_rd);
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + SUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row <= row;
      out_col <= cmd.j;
      dot_sum <= acc;
      last    <= cmd.out_last;
    end
  end

  assign status.drained  = !cmd.issue && !rd_valid && !prod_valid;
  assign status.out_free = !out_valid || !out_stall;

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a beat that was not taken");

  a_load_settled: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rd_valid && !prod_valid))
    else $error("result loaded while products were still in flight");

  a_clear_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_clear |-> (!rd_valid && !prod_valid))
    else $error("accumulator cleared while a product was pending");

endmodule

// ===== rtl/mme_ctrl.sv =====
// Controller: configuration registers, input decode and the row/column/depth sequencer.
module mme_ctrl
  import mme_pkg::*;
#(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int MAX_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [IDX_W-1:0]     row_index,
  input  status_t              status,
  output cmd_t                 cmd
);

  localparam int COL_CAP = (MAX_COLS < 64) ? MAX_COLS : 64;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [DIM_W-1:0] rows_m;
  logic [DIM_W-1:0] cols_n;
  logic [DIM_W-1:0] depth_k;
  logic             transpose_b;
  logic [DIM_W-1:0] m_eff;
  logic [DIM_W-1:0] n_eff;
  logic [DIM_W-1:0] kd_eff;
  logic [DIM_W-1:0] k;
  logic [DIM_W-1:0] k_next;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] j_next;
  logic             accept;
  logic             col_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m      <= DIM_W'(64);
      cols_n      <= DIM_W'(64);
      depth_k     <= DIM_W'(64);
      transpose_b <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_M:      rows_m      <= cfg_data;
        REG_COLS_N:      cols_n      <= cfg_data;
        REG_DEPTH_K:     depth_k     <= cfg_data;
        REG_TRANSPOSE_B: transpose_b <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Zero acts as one; values above the store geometry act as its limit.
  always_comb begin
    m_eff  = (rows_m == '0) ? DIM_W'(1) :
             (32'(rows_m) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_m;
    n_eff  = (cols_n == '0) ? DIM_W'(1) :
             (32'(cols_n) > COL_CAP) ? DIM_W'(COL_CAP) : cols_n;
    kd_eff = (depth_k == '0) ? DIM_W'(1) :
             (32'(depth_k) > MAX_DEPTH) ? DIM_W'(MAX_DEPTH) : depth_k;
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign col_last = ({1'b0, j} == (n_eff - DIM_W'(1)));

  always_comb begin
    state_next    = state;
    k_next        = k;
    j_next        = j;
    cmd           = '0;
    cmd.b_swap    = transpose_b;
    cmd.k         = k;
    cmd.j         = j;
    cmd.out_last  = col_last;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.wr_a = (operation == OP_LOAD_A);
          cmd.wr_b = (operation == OP_LOAD_B);
          if ((operation == OP_COMPUTE) && ({1'b0, row_index} < m_eff)) begin
            cmd.latch_row = 1'b1;
            k_next        = '0;
            j_next        = '0;
            state_next    = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.issue     = 1'b1;
        cmd.acc_clear = (k == '0);
        if (k == (kd_eff - DIM_W'(1))) begin
          state_next = S_FLUSH;
        end else begin
          k_next = k + DIM_W'(1);
        end
      end
      S_FLUSH: begin
        if (status.drained && status.out_free) begin
          cmd.out_load = 1'b1;
          k_next       = '0;
          if (col_last) begin
            state_next = S_IDLE;
          end else begin
            j_next     = j + IDX_W'(1);
            state_next = S_MAC;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      j     <= j_next;
    end
  end

  a_last_ends_row: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_last) |=> (state == S_IDLE))
    else $error("row did not finish after its last column");

  a_mac_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (k < kd_eff))
    else $error("depth counter ran past the inner dimension");

  a_col_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> ({1'b0, j} < n_eff))
    else $error("column counter ran past the row length");

endmodule
